// ===== rtl/core/rmrb_pkg.sv =====
package rmrb_pkg;

  // Store geometry.
  localparam int unsigned BUFFER_BYTES = 1024;
  localparam int unsigned PREFIX_BYTES = 2;
  localparam int unsigned HEADER_BYTES = 6;

  localparam int unsigned ADDR_W = $clog2(BUFFER_BYTES);
  localparam int unsigned CNT_W  = $clog2(BUFFER_BYTES + 1);
  localparam int unsigned MSG_W  = $clog2(BUFFER_BYTES / PREFIX_BYTES + 1);
  localparam int unsigned POS_W  = $clog2(BUFFER_BYTES + HEADER_BYTES);
  localparam int unsigned TOT_W  = $clog2(BUFFER_BYTES + HEADER_BYTES + 1);

  // Field widths of the stream items.
  localparam int unsigned KIND_W   = 2;
  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned LEN_W    = 16;
  localparam int unsigned IDX_W    = 32;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned USED_W   = 11;
  localparam int unsigned QUEUED_W = 10;

  typedef enum logic [KIND_W-1:0] {
    KIND_BEGIN   = 2'd0,
    KIND_PAYLOAD = 2'd1,
    KIND_ACK     = 2'd2,
    KIND_FETCH   = 2'd3
  } kind_e;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK       = 3'd0,
    STAT_OVERFLOW = 3'd1,
    STAT_STRAY    = 3'd2,
    STAT_STALE    = 3'd3,
    STAT_BEYOND   = 3'd4
  } status_e;

  typedef struct packed {
    kind_e             kind;
    logic [BYTE_W-1:0] pbyte;
    logic [LEN_W-1:0]  mlen;
    logic [IDX_W-1:0]  ack;
  } req_t;

  typedef struct packed {
    status_e             status;
    logic [BYTE_W-1:0]   obyte;
    logic                olast;
    logic [USED_W-1:0]   used;
    logic [QUEUED_W-1:0] queued;
    logic [IDX_W-1:0]    front;
  } res_t;

endpackage

// ===== rtl/core/rmrb_store.sv =====
module rmrb_store (
  input  logic                          clk_i,
  input  logic                          we_i,
  input  logic [rmrb_pkg::ADDR_W-1:0]   waddr_i,
  input  logic [rmrb_pkg::BYTE_W-1:0]   wdata_i,
  input  logic [rmrb_pkg::ADDR_W-1:0]   raddr_i,
  output logic [rmrb_pkg::BYTE_W-1:0]   rdata_o
);
  import rmrb_pkg::*;

  logic [BYTE_W-1:0] mem_q [BUFFER_BYTES];
  logic [BYTE_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/rmrb_wrap_add.sv =====
module rmrb_wrap_add (
  input  logic [rmrb_pkg::ADDR_W-1:0] base_i,
  input  logic [rmrb_pkg::CNT_W-1:0]  offs_i,
  output logic [rmrb_pkg::ADDR_W-1:0] sum_o
);
  import rmrb_pkg::*;

  logic [CNT_W:0] raw;

  // Both operands stay within one buffer length, so one subtract wraps the sum.
  always_comb begin
    raw = (CNT_W + 1)'(base_i) + (CNT_W + 1)'(offs_i);
    if (raw >= (CNT_W + 1)'(BUFFER_BYTES)) begin
      raw = raw - (CNT_W + 1)'(BUFFER_BYTES);
    end
    sum_o = ADDR_W'(raw);
  end

endmodule

// ===== rtl/core/rmrb_ctrl.sv =====
module rmrb_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 req_valid_i,
  output logic                 req_ready_o,
  input  rmrb_pkg::req_t       req_i,
  output logic                 res_valid_o,
  input  logic                 res_take_i,
  output rmrb_pkg::res_t       res_o
);
  import rmrb_pkg::*;

  localparam int unsigned CHK_W = ((LEN_W > CNT_W) ? LEN_W : CNT_W) + 2;
  localparam int unsigned POS_CNT_HI = HEADER_BYTES - 2;
  localparam int unsigned POS_CNT_LO = HEADER_BYTES - 1;

  typedef enum logic [3:0] {
    S_IDLE,
    S_EXEC,
    S_BEGIN_HI,
    S_BEGIN_LO,
    S_ACK_HI,
    S_ACK_LO,
    S_ACK_DROP,
    S_FETCH,
    S_RESP
  } state_e;

  state_e              state_q, state_d;
  req_t                req_q, req_d;
  logic [ADDR_W-1:0]   head_q, head_d;
  logic [ADDR_W-1:0]   tail_q, tail_d;
  logic [CNT_W-1:0]    committed_q, committed_d;
  logic [MSG_W-1:0]    total_q, total_d;
  logic [IDX_W-1:0]    front_q, front_d;
  logic [LEN_W-1:0]    pending_q, pending_d;
  logic [LEN_W-1:0]    open_len_q, open_len_d;
  logic [POS_W-1:0]    pos_q, pos_d;
  logic [MSG_W-1:0]    drop_q, drop_d;
  logic [BYTE_W-1:0]   prefix_hi_q, prefix_hi_d;
  status_e             status_q, status_d;
  logic [BYTE_W-1:0]   obyte_q, obyte_d;
  logic                olast_q, olast_d;

  // Shared address adder and store port.
  logic [ADDR_W-1:0]   wa_base, wa_sum;
  logic [CNT_W-1:0]    wa_offs;
  logic                mem_we;
  logic [ADDR_W-1:0]   mem_waddr, mem_raddr;
  logic [BYTE_W-1:0]   mem_wdata, mem_rdata;

  logic [CHK_W-1:0]    need;
  logic                overflow;
  logic [IDX_W:0]      front_end;
  logic [IDX_W-1:0]    ack_gap;
  logic [LEN_W-1:0]    prefix;
  logic [CHK_W-1:0]    size_raw;
  logic [CNT_W-1:0]    size_c;
  logic [TOT_W-1:0]    read_total;
  logic [POS_W-1:0]    p_eff;
  logic [POS_W-1:0]    p_body;
  logic [15:0]         msg16;

  rmrb_wrap_add u_wrap (
    .base_i (wa_base),
    .offs_i (wa_offs),
    .sum_o  (wa_sum)
  );

  rmrb_store u_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  always_comb begin
    need       = CHK_W'(req_q.mlen) + CHK_W'(PREFIX_BYTES) + CHK_W'(committed_q);
    overflow   = need > CHK_W'(BUFFER_BYTES);
    front_end  = {1'b0, front_q} + (IDX_W + 1)'(total_q);
    ack_gap    = req_q.ack - front_q;
    prefix     = {prefix_hi_q, mem_rdata};
    size_raw   = CHK_W'(prefix) + CHK_W'(PREFIX_BYTES);
    // A damaged prefix never removes more than the committed bytes.
    size_c     = (size_raw > CHK_W'(committed_q)) ? committed_q : CNT_W'(size_raw);
    read_total = TOT_W'(HEADER_BYTES) + TOT_W'(committed_q);
    p_eff      = (TOT_W'(pos_q) >= read_total) ? '0 : pos_q;
    p_body     = p_eff - POS_W'(HEADER_BYTES);
    msg16      = 16'(total_q);
  end

  always_comb begin
    wa_base = head_q;
    wa_offs = '0;
    unique case (state_q)
      S_EXEC: begin
        case (req_q.kind)
          KIND_PAYLOAD: begin
            wa_base = tail_q;
            wa_offs = CNT_W'(1);
          end
          KIND_FETCH: wa_offs = CNT_W'(p_body);
          default:    wa_offs = committed_q;
        endcase
      end
      S_BEGIN_HI, S_BEGIN_LO: begin
        wa_base = tail_q;
        wa_offs = CNT_W'(1);
      end
      S_ACK_LO:   wa_offs = CNT_W'(1);
      S_ACK_DROP: wa_offs = size_c;
      default:    wa_offs = '0;
    endcase
  end

  always_comb begin
    state_d     = state_q;
    req_d       = req_q;
    head_d      = head_q;
    tail_d      = tail_q;
    committed_d = committed_q;
    total_d     = total_q;
    front_d     = front_q;
    pending_d   = pending_q;
    open_len_d  = open_len_q;
    pos_d       = pos_q;
    drop_d      = drop_q;
    prefix_hi_d = prefix_hi_q;
    status_d    = status_q;
    obyte_d     = obyte_q;
    olast_d     = olast_q;
    mem_we      = 1'b0;
    mem_waddr   = tail_q;
    mem_wdata   = req_q.pbyte;
    mem_raddr   = head_q;

    unique case (state_q)
      S_IDLE: begin
        if (req_valid_i) begin
          req_d   = req_i;
          state_d = S_EXEC;
        end
      end

      S_EXEC: begin
        status_d = STAT_OK;
        obyte_d  = '0;
        olast_d  = 1'b0;
        state_d  = S_RESP;
        if (req_q.kind != KIND_FETCH) begin
          pos_d = '0;
        end
        case (req_q.kind)
          KIND_BEGIN: begin
            // An unfinished message is dropped by restarting at the committed end.
            pending_d  = '0;
            tail_d     = wa_sum;
            open_len_d = req_q.mlen;
            if (overflow) begin
              status_d = STAT_OVERFLOW;
            end else begin
              state_d = S_BEGIN_HI;
            end
          end

          KIND_PAYLOAD: begin
            if (pending_q == '0) begin
              status_d = STAT_STRAY;
            end else begin
              mem_we    = 1'b1;
              tail_d    = wa_sum;
              pending_d = pending_q - LEN_W'(1);
              if (pending_q == LEN_W'(1)) begin
                committed_d = committed_q + CNT_W'(open_len_q) + CNT_W'(PREFIX_BYTES);
                total_d     = total_q + MSG_W'(1);
              end
            end
          end

          KIND_ACK: begin
            if (total_q == '0) begin
              front_d = req_q.ack + IDX_W'(1);
            end else if (req_q.ack < front_q) begin
              status_d = STAT_STALE;
            end else if ({1'b0, req_q.ack} >= front_end) begin
              head_d      = wa_sum;
              committed_d = '0;
              total_d     = '0;
              front_d     = req_q.ack + IDX_W'(1);
              status_d    = STAT_BEYOND;
            end else begin
              // The gap is below the message count here, so it fits the count width.
              drop_d  = MSG_W'(ack_gap) + MSG_W'(1);
              state_d = S_ACK_HI;
            end
          end

          default: begin
            if (TOT_W'(p_eff) + TOT_W'(1) >= read_total) begin
              olast_d = 1'b1;
              pos_d   = '0;
            end else begin
              pos_d = p_eff + POS_W'(1);
            end
            if (p_eff < POS_W'(POS_CNT_HI)) begin
              case (p_eff[1:0])
                2'd0:    obyte_d = front_q[31:24];
                2'd1:    obyte_d = front_q[23:16];
                2'd2:    obyte_d = front_q[15:8];
                default: obyte_d = front_q[7:0];
              endcase
            end else if (p_eff == POS_W'(POS_CNT_HI)) begin
              obyte_d = msg16[15:8];
            end else if (p_eff == POS_W'(POS_CNT_LO)) begin
              obyte_d = msg16[7:0];
            end else begin
              mem_raddr = wa_sum;
              state_d   = S_FETCH;
            end
          end
        endcase
      end

      S_BEGIN_HI: begin
        mem_we    = 1'b1;
        mem_wdata = req_q.mlen[15:8];
        tail_d    = wa_sum;
        state_d   = S_BEGIN_LO;
      end

      S_BEGIN_LO: begin
        mem_we    = 1'b1;
        mem_wdata = req_q.mlen[7:0];
        tail_d    = wa_sum;
        state_d   = S_RESP;
        if (req_q.mlen == '0) begin
          committed_d = committed_q + CNT_W'(open_len_q) + CNT_W'(PREFIX_BYTES);
          total_d     = total_q + MSG_W'(1);
        end else begin
          pending_d = req_q.mlen;
        end
      end

      S_ACK_HI: begin
        mem_raddr = head_q;
        state_d   = S_ACK_LO;
      end

      S_ACK_LO: begin
        mem_raddr   = wa_sum;
        prefix_hi_d = mem_rdata;
        state_d     = S_ACK_DROP;
      end

      S_ACK_DROP: begin
        head_d      = wa_sum;
        committed_d = committed_q - size_c;
        total_d     = total_q - MSG_W'(1);
        front_d     = front_q + IDX_W'(1);
        drop_d      = drop_q - MSG_W'(1);
        state_d     = (drop_q == MSG_W'(1)) ? S_RESP : S_ACK_HI;
      end

      S_FETCH: begin
        obyte_d = mem_rdata;
        state_d = S_RESP;
      end

      S_RESP: begin
        if (res_take_i) begin
          state_d = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      req_q       <= '0;
      head_q      <= '0;
      tail_q      <= '0;
      committed_q <= '0;
      total_q     <= '0;
      front_q     <= '0;
      pending_q   <= '0;
      open_len_q  <= '0;
      pos_q       <= '0;
      drop_q      <= '0;
      prefix_hi_q <= '0;
      status_q    <= STAT_OK;
      obyte_q     <= '0;
      olast_q     <= 1'b0;
    end else begin
      state_q     <= state_d;
      req_q       <= req_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      committed_q <= committed_d;
      total_q     <= total_d;
      front_q     <= front_d;
      pending_q   <= pending_d;
      open_len_q  <= open_len_d;
      pos_q       <= pos_d;
      drop_q      <= drop_d;
      prefix_hi_q <= prefix_hi_d;
      status_q    <= status_d;
      obyte_q     <= obyte_d;
      olast_q     <= olast_d;
    end
  end

  assign req_ready_o  = (state_q == S_IDLE);
  assign res_valid_o  = (state_q == S_RESP);
  assign res_o.status = status_q;
  assign res_o.obyte  = obyte_q;
  assign res_o.olast  = olast_q;
  assign res_o.used   = USED_W'(committed_q);
  assign res_o.queued = QUEUED_W'(total_q);
  assign res_o.front  = front_q;

endmodule

// ===== rtl/core/reliable_message_retransmit_buffer_unit.sv =====
// Each accepted beat runs through the sequencer to a result beat on the output: payload,
// stray, rejected begins, acks that remove nothing or empty the queue at once, and
// header fetches pass execute and respond only; body fetches add a store read,
// accepted begins write the two prefix bytes, and acks that remove N messages do
// two prefix reads and one update each. A new beat is taken once the sequencer is back in idle.
// Reset clears all pointers and counts at once; store contents stay undefined.
module reliable_message_retransmit_buffer_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [55:0] s_axis_tdata_i,  // payload_byte[7:0], message_length[23:8], ack_index[55:24]
  input  logic [1:0]  s_axis_tuser_i,  // kind[1:0]
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [63:0] m_axis_tdata_o,  // out_byte[7:0], used_bytes[18:8],
                                       // queued_messages[28:19], next_front_index[60:29]
  output logic [2:0]  m_axis_tuser_o,  // status[2:0]
  output logic        m_axis_tlast_o   // out_last
);
  import rmrb_pkg::*;

  req_t req;
  res_t res;
  logic res_valid;
  logic slot_free;
  logic out_valid_q;
  res_t out_q;

  assign req.kind  = kind_e'(s_axis_tuser_i);
  assign req.pbyte = s_axis_tdata_i[7:0];
  assign req.mlen  = s_axis_tdata_i[23:8];
  assign req.ack   = s_axis_tdata_i[55:24];

  // The output register frees up in the same cycle its beat is taken.
  assign slot_free = !out_valid_q || m_axis_tready_i;

  rmrb_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (s_axis_tvalid_i),
    .req_ready_o (s_axis_tready_o),
    .req_i       (req),
    .res_valid_o (res_valid),
    .res_take_i  (slot_free),
    .res_o       (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_valid && slot_free) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && slot_free) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {3'b000, out_q.front, out_q.queued, out_q.used, out_q.obyte};
  assign m_axis_tuser_o  = out_q.status;
  assign m_axis_tlast_o  = out_q.olast;

endmodule

// ===== dv/tb.sv =====
module tb;
  import rmrb_pkg::*;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        s_axis_tvalid_i;
  logic        s_axis_tready_o;
  logic [55:0] s_axis_tdata_i;  // payload_byte[7:0], message_length[23:8], ack_index[55:24]
  logic [1:0]  s_axis_tuser_i;  // kind[1:0]
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i;
  logic [63:0] m_axis_tdata_o;  // out_byte[7:0], used_bytes[18:8],
                                // queued_messages[28:19], next_front_index[60:29]
  logic [2:0]  m_axis_tuser_o;  // status[2:0]
  logic        m_axis_tlast_o;  // out_last

  always #5 clk_i = ~clk_i;

  reliable_message_retransmit_buffer_unit DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

  // Shadow copy of the retransmit queue, advanced once per accepted input beat.
  logic [7:0]  shadow_store [BUFFER_BYTES];
  int unsigned sh_head, sh_tail, sh_used, sh_queued, sh_pend, sh_rdpos;
  logic [31:0] sh_front;

  res_t        want_results [$];
  res_t        head_exp;
  int unsigned mismatches = 0;
  int unsigned beats_sent = 0;
  bit          calm = 1'b0;

  typedef struct {
    req_t item;
    bit   typed;
    res_t want;
  } step_t;

  localparam int N_STEPS = 24;

  step_t steps [N_STEPS] = '{
    // Header byte of an empty queue right after reset.
    '{'{KIND_FETCH, 8'h00, 16'h0000, 32'h0000_0000}, 1'b1,
      '{STAT_OK, 8'h00, 1'b0, 11'd0, 10'd0, 32'h0000_0000}},
    // An ack on an empty queue moves the front to ack + 1.
    '{'{KIND_ACK, 8'h00, 16'h0000, 32'hFFFF_FFFE}, 1'b1,
      '{STAT_OK, 8'h00, 1'b0, 11'd0, 10'd0, 32'hFFFF_FFFF}},
    '{'{KIND_PAYLOAD, 8'hFF, 16'h0000, 32'h0000_0000}, 1'b1,
      '{STAT_STRAY, 8'h00, 1'b0, 11'd0, 10'd0, 32'hFFFF_FFFF}},
    '{'{KIND_BEGIN, 8'h00, 16'hFFFF, 32'h0000_0000}, 1'b1,
      '{STAT_OVERFLOW, 8'h00, 1'b0, 11'd0, 10'd0, 32'hFFFF_FFFF}},
    // A zero-length message commits on its begin beat.
    '{'{KIND_BEGIN, 8'h00, 16'h0000, 32'h0000_0000}, 1'b1,
      '{STAT_OK, 8'h00, 1'b0, 11'd2, 10'd1, 32'hFFFF_FFFF}},
    '{'{KIND_BEGIN, 8'h00, 16'h0003, 32'h0000_0000}, 1'b1,
      '{STAT_OK, 8'h00, 1'b0, 11'd2, 10'd1, 32'hFFFF_FFFF}},
    '{'{KIND_PAYLOAD, 8'hA5, 16'h0000, 32'h0000_0000}, 1'b0, '0},
    '{'{KIND_PAYLOAD, 8'h00, 16'h0000, 32'h0000_0000}, 1'b0, '0},
    '{'{KIND_PAYLOAD, 8'hFF, 16'h0000, 32'h0000_0000}, 1'b0, '0},
    '{'{KIND_BEGIN, 8'h00, 16'h0002, 32'h0000_0000}, 1'b0, '0},
    '{'{KIND_PAYLOAD, 8'h11, 16'h0000, 32'h0000_0000}, 1'b0, '0},
    // This begin drops the unfinished message.
    '{'{KIND_BEGIN, 8'h00, 16'h0001, 32'h0000_0000}, 1'b0, '0},
    '{'{KIND_PAYLOAD, 8'h22, 16'h0000, 32'h0000_0000}, 1'b0, '0},
    '{'{KIND_FETCH, 8'h00, 16'h0000, 32'h0000_0000}, 1'b0, '0},
    '{'{KIND_FETCH, 8'h00, 16'h0000, 32'h0000_0000}, 1'b0, '0},
    '{'{KIND_ACK, 8'h00, 16'h0000, 32'h0000_0005}, 1'b1,
      '{STAT_STALE, 8'h00, 1'b0, 11'd10, 10'd3, 32'hFFFF_FFFF}},
    // The front index wraps through zero while messages are removed.
    '{'{KIND_ACK, 8'h00, 16'h0000, 32'hFFFF_FFFF}, 1'b0, '0},
    '{'{KIND_ACK, 8'h00, 16'h0000, 32'h0000_0000}, 1'b0, '0},
    '{'{KIND_ACK, 8'h00, 16'h0000, 32'h0000_0007}, 1'b1,
      '{STAT_BEYOND, 8'h00, 1'b0, 11'd0, 10'd0, 32'h0000_0008}},
    '{'{KIND_BEGIN, 8'h00, 16'd1023, 32'h0000_0000}, 1'b1,
      '{STAT_OVERFLOW, 8'h00, 1'b0, 11'd0, 10'd0, 32'h0000_0008}},
    '{'{KIND_BEGIN, 8'h00, 16'd1022, 32'h0000_0000}, 1'b1,
      '{STAT_OK, 8'h00, 1'b0, 11'd0, 10'd0, 32'h0000_0008}},
    '{'{KIND_BEGIN, 8'h00, 16'h0000, 32'h0000_0000}, 1'b1,
      '{STAT_OK, 8'h00, 1'b0, 11'd2, 10'd1, 32'h0000_0008}},
    '{'{KIND_FETCH, 8'h00, 16'h0000, 32'h0000_0000}, 1'b0, '0},
    '{'{KIND_ACK, 8'h00, 16'h0000, 32'hFFFF_FFFF}, 1'b1,
      '{STAT_BEYOND, 8'h00, 1'b0, 11'd0, 10'd0, 32'h0000_0000}}
  };

  function automatic int unsigned prefix_at(int unsigned pos);
    return {shadow_store[pos % BUFFER_BYTES], shadow_store[(pos + 1) % BUFFER_BYTES]};
  endfunction

  function automatic void put_byte(logic [7:0] b);
    shadow_store[sh_tail] = b;
    sh_tail = (sh_tail + 1) % BUFFER_BYTES;
  endfunction

  function automatic void commit_message();
    sh_used   = sh_used + prefix_at(sh_head + sh_used) + PREFIX_BYTES;
    sh_queued = sh_queued + 1;
  endfunction

  function automatic res_t advance_retx_queue(req_t it);
    res_t        r;
    int unsigned total, p, n, sz;
    r = '0;
    r.status = STAT_OK;
    if (it.kind != KIND_FETCH) sh_rdpos = 0;
    case (it.kind)
      KIND_BEGIN: begin
        sh_pend = 0;
        sh_tail = (sh_head + sh_used) % BUFFER_BYTES;
        if (it.mlen + PREFIX_BYTES > BUFFER_BYTES - sh_used) begin
          r.status = STAT_OVERFLOW;
        end else begin
          put_byte(it.mlen[15:8]);
          put_byte(it.mlen[7:0]);
          if (it.mlen == 0) commit_message();
          else sh_pend = it.mlen;
        end
      end
      KIND_PAYLOAD: begin
        if (sh_pend == 0) begin
          r.status = STAT_STRAY;
        end else begin
          put_byte(it.pbyte);
          sh_pend = sh_pend - 1;
          if (sh_pend == 0) commit_message();
        end
      end
      KIND_ACK: begin
        if (sh_queued == 0) begin
          sh_front = it.ack + 32'd1;
        end else if (it.ack < sh_front) begin
          r.status = STAT_STALE;
        end else if ({32'h0, it.ack} >= {32'h0, sh_front} + 64'(sh_queued)) begin
          sh_head   = (sh_head + sh_used) % BUFFER_BYTES;
          sh_used   = 0;
          sh_queued = 0;
          sh_front  = it.ack + 32'd1;
          r.status  = STAT_BEYOND;
        end else begin
          // Cumulative ack: walk the prefixes of the oldest messages.
          n = it.ack - sh_front + 32'd1;
          while (n > 0 && sh_queued > 0) begin
            sz = prefix_at(sh_head) + PREFIX_BYTES;
            if (sz > sh_used) sz = sh_used;
            sh_head   = (sh_head + sz) % BUFFER_BYTES;
            sh_used   = sh_used - sz;
            sh_queued = sh_queued - 1;
            sh_front  = sh_front + 32'd1;
            n = n - 1;
          end
        end
      end
      KIND_FETCH: begin
        total = HEADER_BYTES + sh_used;
        p = sh_rdpos;
        if (p >= total) p = 0;
        if (p < 4) r.obyte = 8'(sh_front >> (8 * (3 - p)));
        else if (p == 4) r.obyte = 8'(sh_queued >> 8);
        else if (p == 5) r.obyte = 8'(sh_queued);
        else r.obyte = shadow_store[(sh_head + p - HEADER_BYTES) % BUFFER_BYTES];
        if (p + 1 >= total) begin
          r.olast  = 1'b1;
          sh_rdpos = 0;
        end else begin
          sh_rdpos = p + 1;
        end
      end
    endcase
    r.used   = USED_W'(sh_used);
    r.queued = QUEUED_W'(sh_queued);
    r.front  = sh_front;
    return r;
  endfunction

  function automatic req_t rand_item(kind_e k);
    req_t r;
    r.kind  = k;
    r.pbyte = 8'($urandom);
    r.mlen  = 16'($urandom);
    r.ack   = $urandom;
    return r;
  endfunction

  task automatic flag_mismatch(input string what, input logic [63:0] got,
                               input logic [63:0] want);
    $display("%0t: %s mismatch, got %0h expected %0h", $time, what, got, want);
    mismatches++;
  endtask

  // Called on a falling edge; returns on the falling edge after the beat is taken.
  task automatic send_item(input req_t it, input bit typed = 1'b0, input res_t fixed = '0);
    int   gap;
    res_t predicted;
    gap = calm ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tuser_i  <= it.kind;
    s_axis_tdata_i  <= {it.ack, it.mlen, it.pbyte};
    do @(posedge clk_i); while (!s_axis_tready_o);
    predicted = advance_retx_queue(it);
    want_results.push_back(typed ? fixed : predicted);
    beats_sent++;
    @(negedge clk_i);
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (want_results.size() == 0) begin
        flag_mismatch("unexpected result beat", m_axis_tdata_o, '0);
      end else begin
        head_exp = want_results.pop_front();
        if (m_axis_tuser_o !== head_exp.status)
          flag_mismatch("status", m_axis_tuser_o, head_exp.status);
        if (m_axis_tdata_o[7:0] !== head_exp.obyte)
          flag_mismatch("out_byte", m_axis_tdata_o[7:0], head_exp.obyte);
        if (m_axis_tlast_o !== head_exp.olast)
          flag_mismatch("out_last", m_axis_tlast_o, head_exp.olast);
        if (m_axis_tdata_o[18:8] !== head_exp.used)
          flag_mismatch("used_bytes", m_axis_tdata_o[18:8], head_exp.used);
        if (m_axis_tdata_o[28:19] !== head_exp.queued)
          flag_mismatch("queued_messages", m_axis_tdata_o[28:19], head_exp.queued);
        if (m_axis_tdata_o[60:29] !== head_exp.front)
          flag_mismatch("next_front_index", m_axis_tdata_o[60:29], head_exp.front);
      end
    end
  end

  initial begin : result_sink
    int stall;
    m_axis_tready_i = 1'b0;
    wait (rst_ni === 1'b1);
    @(negedge clk_i);
    forever begin
      stall = calm ? 0 : $urandom_range(0, 4);
      if (stall > 0) begin
        m_axis_tready_i <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      m_axis_tready_i <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid_o);
      @(negedge clk_i);
    end
  end

  initial begin : watchdog
    #100_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin : stimulus
    req_t        r;
    int unsigned len, n, sel;
    bit          filled;
    filled          = 1'b0;
    rst_ni          = 1'b0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i  = '0;
    s_axis_tuser_i  = '0;
    foreach (shadow_store[i]) shadow_store[i] = '0;
    sh_head   = 0;
    sh_tail   = 0;
    sh_used   = 0;
    sh_queued = 0;
    sh_pend   = 0;
    sh_rdpos  = 0;
    sh_front  = '0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (steps[i]) send_item(steps[i].item, steps[i].typed, steps[i].want);

    while (beats_sent < 900) begin
      calm = ($urandom_range(0, 7) == 0);
      sel  = $urandom_range(0, 99);
      if (!filled && beats_sent >= 300) begin
        // Empty the queue, then fill the whole store with zero-length messages.
        if (sh_queued > 0) begin
          r = rand_item(KIND_ACK);
          r.ack = sh_front + sh_queued - 1;
          send_item(r);
        end
        while (sh_used + PREFIX_BYTES <= BUFFER_BYTES) begin
          r = rand_item(KIND_BEGIN);
          r.mlen = '0;
          send_item(r);
        end
        r = rand_item(KIND_BEGIN);
        r.mlen = '0;
        send_item(r);
        repeat (8) send_item(rand_item(KIND_FETCH));
        r = rand_item(KIND_ACK);
        r.ack = sh_front + sh_queued - 1;
        send_item(r);
        filled = 1'b1;
      end else if (sel < 45) begin
        sel = $urandom_range(0, 99);
        if (sel < 55) len = $urandom_range(0, 6);
        else if (sel < 85) len = $urandom_range(7, 40);
        else if (sel < 93) len = $urandom_range(41, 120);
        else len = $urandom_range(1024, 65535);
        r = rand_item(KIND_BEGIN);
        r.mlen = 16'(len);
        send_item(r);
        // Mostly complete messages; some are cut short, some run one byte over.
        n   = sh_pend;
        sel = $urandom_range(0, 19);
        if (sel == 0) n = $urandom_range(0, n);
        else if (sel == 1) n = n + 1;
        repeat (n) send_item(rand_item(KIND_PAYLOAD));
      end else if (sel < 65) begin
        r   = rand_item(KIND_ACK);
        sel = $urandom_range(0, 99);
        if (sh_queued == 0) begin
          if (sel < 70) r.ack = sh_front + $urandom_range(0, 3);
        end else if (sel < 60) begin
          r.ack = sh_front + $urandom_range(0, sh_queued - 1);
        end else if (sel < 75) begin
          r.ack = sh_front + sh_queued + $urandom_range(0, 3);
        end else if (sel < 90) begin
          r.ack = sh_front - $urandom_range(1, 3);
        end
        send_item(r);
      end else if (sel < 90) begin
        n   = $urandom_range(1, 8);
        sel = $urandom_range(0, 9);
        if (sh_used <= 200) begin
          if (sel < 5) n = HEADER_BYTES + sh_used;
          else if (sel >= 8) n = HEADER_BYTES + sh_used + $urandom_range(1, 4);
        end
        repeat (n) send_item(rand_item(KIND_FETCH));
      end else begin
        repeat ($urandom_range(1, 3)) send_item(rand_item(kind_e'($urandom_range(0, 3))));
      end
    end
    s_axis_tvalid_i <= 1'b0;

    for (int w = 0; w < 20000 && want_results.size() > 0; w++) @(posedge clk_i);
    if (want_results.size() > 0)
      flag_mismatch("results never delivered", want_results.size(), '0);
    repeat (50) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
